// ----- rtl/fcpi_pkg.sv -----
package fcpi_pkg;

  // Fixed behaviour of the controller.
  localparam int unsigned POLE_PAIRS      = 7;
  localparam int unsigned FILTER_SHIFT    = 3;
  localparam int unsigned STALL_TICKS     = 10000;
  localparam int unsigned SLEW_STEP       = 256;
  localparam int unsigned IQ_LIMIT        = 16384;
  localparam int unsigned SINE_TABLE_BITS = 10;

  // Shared multiplier: signed 33 x signed 18.
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned IN_USED_W  = 114;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [0:0] OP_CURRENT = 1'b0;
  localparam logic [0:0] OP_TICK    = 1'b1;

  localparam logic [1:0] GRP_VELOCITY = 2'd1;
  localparam logic [1:0] GRP_ANGLE    = 2'd2;

  typedef enum logic [2:0] {
    REG_CONTROL_MODE   = 3'd0,
    REG_VEL_KP         = 3'd1,
    REG_VEL_KI         = 3'd2,
    REG_POS_KP         = 3'd3,
    REG_CUR_KP         = 3'd4,
    REG_CUR_KI         = 3'd5,
    REG_VOLTAGE_LIMIT  = 3'd6,
    REG_VELOCITY_LIMIT = 3'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLK0, ST_CLK1, ST_CLK2,
    ST_SIN_INIT, ST_SIN_M0, ST_SIN_M1, ST_SIN_M2, ST_SIN_M3, ST_SIN_M4, ST_SIN_M5,
    ST_PARK0, ST_PARK1, ST_PARK2, ST_PARK3, ST_PARK4,
    ST_T_ANGLE, ST_T_FILT, ST_T_ELEC, ST_T_VEL, ST_T_CUR,
    ST_PI_P, ST_PI_I, ST_PI_A, ST_PI_O,
    ST_T_SLEW, ST_T_STALL, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PI_POS,
    PI_VEL,
    PI_CUR
  } pi_sel_e;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
    logic signed [31:0] r;
    if (x > 44'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -44'sh0_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [33:0] x);
    logic signed [15:0] r;
    if (x > 34'sd32767) r = 16'sh7FFF;
    else if (x < -34'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

  // Symmetric clamp; a zero limit leaves the value alone.
  function automatic logic signed [31:0] clamp_lim(input logic signed [31:0] x,
                                                   input logic [14:0] lim);
    logic signed [31:0] l;
    logic signed [31:0] r;
    l = $signed({17'd0, lim});
    r = x;
    if (lim != 15'd0) begin
      if (x > l) r = l;
      else if (x < -l) r = -l;
    end
    return r;
  endfunction

  // Division by two rounding toward zero.
  function automatic logic signed [31:0] halve32(input logic signed [31:0] x);
    logic [32:0] t;
    t = {x[31], x} + {32'd0, x[31]};
    return t[32:1];
  endfunction

  function automatic logic signed [15:0] halve16(input logic signed [15:0] x);
    logic [16:0] t;
    t = {x[15], x} + {16'd0, x[15]};
    return t[16:1];
  endfunction

endpackage

// ----- rtl/fcpi_mul.sv -----
module fcpi_mul
  import fcpi_pkg::*;
(
  input  logic                        clk_i,
  input  mul_req_t                    req_i,
  output logic signed [MUL_P_W-1:0]   prod_o
);

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= req_i.a * req_i.b;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/foc_cascaded_pi_step.sv -----
// Channel   Direction  Payload
// s_axis    in         tuser: op; tdata: angle_raw, angle_ok, velocity_in, velocity_ok,
//                      target, phase_a, phase_b, phase_c
// m_axis    out        tdata: voltage_q, elec_angle, velocity_out, current_d, current_q;
//                      tuser: stall_event
// cfg       in         cfg_index_i selects the register, cfg_data_i is written
//
// The length of a control tick depends on the mode and on whether a current sample
// has been taken. The pace is set by the single shared multiplier: each dependent
// step waits for the registered result of the product before it.
// The input is ready only in the idle state; a finished item waits in its last state
// until the output register is free, so a receiver stall holds up the sequence.
// Reset clears all controller state and loads the register defaults.
module foc_cascaded_pi_step
  import fcpi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] angle_raw, [16] angle_ok, [32:17] velocity_in, [33] velocity_ok,
  // [65:34] target, [81:66] phase_a, [97:82] phase_b, [113:98] phase_c
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] voltage_q, [31:16] elec_angle, [47:32] velocity_out,
  // [63:48] current_d, [79:64] current_q
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] stall_event
  output logic [0:0]            m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  localparam logic [15:0] SINE_MASK = 16'(~((1 << (16 - SINE_TABLE_BITS)) - 1));
  localparam logic signed [16:0] SLEW_MAX = 17'(SLEW_STEP);

  state_e  state_q, state_d;
  pi_sel_e pi_sel_q, pi_sel_d;

  // Configuration.
  logic [2:0]  mode_q, mode_d;
  logic [15:0] vel_kp_q, vel_kp_d, vel_ki_q, vel_ki_d, pos_kp_q, pos_kp_d;
  logic [15:0] cur_kp_q, cur_kp_d, cur_ki_q, cur_ki_d;
  logic [14:0] vlim_q, vlim_d, vellim_q, vellim_d;

  // Controller state.
  logic               seen_q, seen_d, cur_valid_q, cur_valid_d;
  logic [15:0]        prev_q, prev_d, elec_q, elec_d, stall_cnt_q, stall_cnt_d;
  logic [31:0]        unwr_q, unwr_d;
  logic signed [16:0] delta_q, delta_d;
  logic signed [31:0] filt_q, filt_d, vel_int_q, vel_int_d, cur_int_q, cur_int_d;
  logic signed [15:0] meas_d_q, meas_d_d, meas_q_q, meas_q_d, slewed_q, slewed_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_stall_q, out_stall_d;

  // Working registers of the sequence.
  logic [IN_USED_W-1:0] dat_q, dat_d;
  logic                 stall_q, stall_d, neg_q, neg_d, cos_pass_q, cos_pass_d;
  logic signed [16:0]   alpha_q, alpha_d, beta_q, beta_d;
  logic [15:0]          z_q, z_d, z2_q, z2_d;
  logic signed [15:0]   sin_q, sin_d, cos_q, cos_d;
  logic signed [33:0]   acc_q, acc_d;
  logic signed [32:0]   err_q, err_d;
  logic signed [42:0]   p_q, p_d;
  logic signed [31:0]   ni_q, ni_d, res_q, res_d;

  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] prod;

  fcpi_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Fields of the held item.
  logic [15:0]        raw, vin, pa, pb, pc;
  logic               angle_ok, vel_ok;
  logic signed [31:0] tgt;

  assign raw      = dat_q[15:0];
  assign angle_ok = dat_q[16];
  assign vin      = dat_q[32:17];
  assign vel_ok   = dat_q[33];
  assign tgt      = dat_q[65:34];
  assign pa       = dat_q[81:66];
  assign pb       = dat_q[97:82];
  assign pc       = dat_q[113:98];

  // Clarke inputs.
  logic [17:0] clk_x;
  logic [16:0] clk_bc;
  assign clk_x  = {pa[15], pa, 1'b0} - {{2{pb[15]}}, pb} - {{2{pc[15]}}, pc};
  assign clk_bc = {pb[15], pb} - {pc[15], pc};

  // Angle unwrap.
  logic signed [17:0] ang_raw_diff, ang_diff;
  assign ang_raw_diff = $signed({2'b00, raw}) - $signed({2'b00, prev_q});
  assign ang_diff = (ang_raw_diff > 18'sd32768)  ? ang_raw_diff - 18'sd65536 :
                    (ang_raw_diff < -18'sd32768) ? ang_raw_diff + 18'sd65536 :
                                                    ang_raw_diff;

  // Velocity filter.
  logic signed [16:0] vel_sel;
  logic signed [33:0] filt_diff, filt_step;
  logic               filt_en;
  assign vel_sel   = vel_ok ? $signed({vin[15], vin}) : delta_q;
  assign filt_en   = vel_ok || seen_q;
  assign filt_diff = $signed({{17{vel_sel[16]}}, vel_sel}) - $signed({{2{filt_q[31]}}, filt_q});
  assign filt_step = filt_diff >>> FILTER_SHIFT;

  // Quarter-wave sine set-up and product slices.
  logic [15:0] trig_p, prod_sh15;
  logic [14:0] trig_r, sine_mag;
  logic signed [15:0] sine_val;
  assign trig_p    = (elec_q & SINE_MASK) + (cos_pass_q ? 16'h4000 : 16'h0000);
  assign trig_r    = trig_p[14] ? 15'd16384 - {1'b0, trig_p[13:0]} : {1'b0, trig_p[13:0]};
  assign prod_sh15 = prod[30:15];
  assign sine_mag  = prod_sh15[15] ? 15'h7FFF : prod_sh15[14:0];
  assign sine_val  = neg_q ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

  logic signed [33:0] park_sum, park_diff;
  assign park_sum  = acc_q + prod[33:0];
  assign park_diff = acc_q - prod[33:0];

  // PI stage shared by all three loops.
  logic signed [31:0] pi_integ, pi_lim_s;
  logic [14:0]        pi_lim;
  logic [15:0]        pi_kp, pi_ki;
  logic signed [42:0] ki_term;
  logic               pi_block;
  logic signed [31:0] pi_ni, pi_out;

  always_comb begin
    case (pi_sel_q)
      PI_POS: begin
        pi_integ = 32'sd0;
        pi_lim   = vellim_q;
        pi_kp    = pos_kp_q;
        pi_ki    = 16'd0;
      end
      PI_VEL: begin
        pi_integ = vel_int_q;
        pi_lim   = vlim_q;
        pi_kp    = vel_kp_q;
        pi_ki    = vel_ki_q;
      end
      PI_CUR: begin
        pi_integ = cur_int_q;
        pi_lim   = vlim_q;
        pi_kp    = cur_kp_q;
        pi_ki    = cur_ki_q;
      end
      default: begin
        pi_integ = 32'sd0;
        pi_lim   = 15'd0;
        pi_kp    = 16'd0;
        pi_ki    = 16'd0;
      end
    endcase
  end

  assign pi_lim_s = $signed({17'd0, pi_lim});
  assign ki_term  = prod[50:8];
  // Integration halts while the integral sits at the limit and the error pushes outward.
  assign pi_block = (pi_lim != 15'd0) &&
                    (((pi_integ >= pi_lim_s) && (err_q > 33'sd0)) ||
                     ((pi_integ <= -pi_lim_s) && (err_q < 33'sd0)));
  assign pi_ni  = clamp_lim(pi_block ? pi_integ :
                    sat32($signed({{12{pi_integ[31]}}, pi_integ}) +
                          $signed({ki_term[42], ki_term})), pi_lim);
  assign pi_out = clamp_lim(sat32($signed({p_q[42], p_q}) +
                                  $signed({{12{ni_q[31]}}, ni_q})), pi_lim);

  // Loop errors.
  logic signed [31:0] vt, iq;
  logic signed [32:0] pos_err, vel_err, cur_err;
  assign vt      = clamp_lim(res_q, vellim_q);
  assign iq      = clamp_lim(res_q, 15'(IQ_LIMIT));
  assign pos_err = $signed({tgt[31], tgt}) - $signed({unwr_q[31], unwr_q});
  assign vel_err = $signed({vt[31], vt}) - $signed({filt_q[31], filt_q});
  assign cur_err = $signed({iq[31], iq}) - $signed({{17{meas_q_q[15]}}, meas_q_q});

  // Voltage clamp and slew.
  logic [14:0]        ulim;
  logic signed [31:0] uq;
  logic signed [16:0] slew_raw, slew_step;
  assign ulim      = (vlim_q != 15'd0) ? vlim_q : 15'h7FFF;
  assign uq        = clamp_lim(res_q, ulim);
  assign slew_raw  = $signed(uq[16:0]) - $signed({slewed_q[15], slewed_q});
  assign slew_step = (slew_raw > SLEW_MAX)  ? SLEW_MAX :
                     (slew_raw < -SLEW_MAX) ? -SLEW_MAX : slew_raw;

  // Stall detection.
  logic [15:0] av;
  logic [31:0] fv;
  logic [20:0] av20;
  logic [19:0] vl17;
  logic [36:0] fv20;
  logic        stall_cond;
  logic [15:0] stall_inc;
  assign av         = slewed_q[15] ? 16'(-slewed_q) : slewed_q;
  assign fv         = filt_q[31] ? 32'(-filt_q) : filt_q;
  assign av20       = {5'd0, av} * 21'd20;
  assign vl17       = {5'd0, vlim_q} * 20'd17;
  assign fv20       = {5'd0, fv} * 37'd20;
  assign stall_cond = (av20 > {1'b0, vl17}) && (fv20 < {22'd0, vellim_q});
  assign stall_inc  = stall_cnt_q + 16'd1;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stall_q;

  always_comb begin
    state_d     = state_q;
    pi_sel_d    = pi_sel_q;
    mode_d      = mode_q;
    vel_kp_d    = vel_kp_q;
    vel_ki_d    = vel_ki_q;
    pos_kp_d    = pos_kp_q;
    cur_kp_d    = cur_kp_q;
    cur_ki_d    = cur_ki_q;
    vlim_d      = vlim_q;
    vellim_d    = vellim_q;
    seen_d      = seen_q;
    cur_valid_d = cur_valid_q;
    prev_d      = prev_q;
    elec_d      = elec_q;
    stall_cnt_d = stall_cnt_q;
    unwr_d      = unwr_q;
    delta_d     = delta_q;
    filt_d      = filt_q;
    vel_int_d   = vel_int_q;
    cur_int_d   = cur_int_q;
    meas_d_d    = meas_d_q;
    meas_q_d    = meas_q_q;
    slewed_d    = slewed_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_stall_d = out_stall_q;
    dat_d       = dat_q;
    stall_d     = stall_q;
    neg_d       = neg_q;
    cos_pass_d  = cos_pass_q;
    alpha_d     = alpha_q;
    beta_d      = beta_q;
    z_d         = z_q;
    z2_d        = z2_q;
    sin_d       = sin_q;
    cos_d       = cos_q;
    acc_d       = acc_q;
    err_d       = err_q;
    p_d         = p_q;
    ni_d        = ni_q;
    res_d       = res_q;
    mul_req     = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          dat_d   = s_axis_tdata[IN_USED_W-1:0];
          stall_d = 1'b0;
          state_d = (s_axis_tuser == OP_TICK) ? ST_T_ANGLE : ST_CLK0;
        end
      end
      ST_CLK0: begin
        mul_req.a = {{15{clk_x[17]}}, clk_x};
        mul_req.b = 18'sd21845;
        state_d   = ST_CLK1;
      end
      ST_CLK1: begin
        alpha_d   = prod[32:16];
        mul_req.a = {{16{clk_bc[16]}}, clk_bc};
        mul_req.b = 18'sd25225;
        state_d   = ST_CLK2;
      end
      ST_CLK2: begin
        beta_d     = prod[32:16];
        cos_pass_d = 1'b0;
        state_d    = ST_SIN_INIT;
      end
      ST_SIN_INIT: begin
        z_d     = {trig_r, 1'b0};
        neg_d   = trig_p[15];
        state_d = ST_SIN_M0;
      end
      ST_SIN_M0: begin
        mul_req.a = {17'd0, z_q};
        mul_req.b = {2'd0, z_q};
        state_d   = ST_SIN_M1;
      end
      ST_SIN_M1: begin
        z2_d      = prod_sh15;
        mul_req.a = {17'd0, prod_sh15};
        mul_req.b = 18'sd153;
        state_d   = ST_SIN_M2;
      end
      ST_SIN_M2: begin
        mul_req.a = {17'd0, 16'd2611 - prod_sh15};
        mul_req.b = {2'd0, z2_q};
        state_d   = ST_SIN_M3;
      end
      ST_SIN_M3: begin
        mul_req.a = {17'd0, 16'd21167 - prod_sh15};
        mul_req.b = {2'd0, z2_q};
        state_d   = ST_SIN_M4;
      end
      ST_SIN_M4: begin
        mul_req.a = {17'd0, 16'd51472 - prod_sh15};
        mul_req.b = {2'd0, z_q};
        state_d   = ST_SIN_M5;
      end
      ST_SIN_M5: begin
        if (!cos_pass_q) begin
          sin_d      = sine_val;
          cos_pass_d = 1'b1;
          state_d    = ST_SIN_INIT;
        end else begin
          cos_d   = sine_val;
          state_d = ST_PARK0;
        end
      end
      ST_PARK0: begin
        mul_req.a = {{16{alpha_q[16]}}, alpha_q};
        mul_req.b = {{2{cos_q[15]}}, cos_q};
        state_d   = ST_PARK1;
      end
      ST_PARK1: begin
        acc_d     = prod[33:0];
        mul_req.a = {{16{beta_q[16]}}, beta_q};
        mul_req.b = {{2{sin_q[15]}}, sin_q};
        state_d   = ST_PARK2;
      end
      ST_PARK2: begin
        meas_d_d  = sat16(park_sum >>> 15);
        mul_req.a = {{16{beta_q[16]}}, beta_q};
        mul_req.b = {{2{cos_q[15]}}, cos_q};
        state_d   = ST_PARK3;
      end
      ST_PARK3: begin
        acc_d     = prod[33:0];
        mul_req.a = {{16{alpha_q[16]}}, alpha_q};
        mul_req.b = {{2{sin_q[15]}}, sin_q};
        state_d   = ST_PARK4;
      end
      ST_PARK4: begin
        meas_q_d    = sat16(park_diff >>> 15);
        cur_valid_d = 1'b1;
        state_d     = ST_DONE;
      end
      ST_T_ANGLE: begin
        if (angle_ok) begin
          if (!seen_q) begin
            seen_d  = 1'b1;
            unwr_d  = {16'd0, raw};
            delta_d = 17'sd0;
          end else begin
            unwr_d  = unwr_q + {{15{ang_diff[16]}}, ang_diff[16:0]};
            delta_d = ang_diff[16:0];
          end
          prev_d = raw;
        end
        state_d = ST_T_FILT;
      end
      ST_T_FILT: begin
        if (filt_en) begin
          filt_d = filt_q + filt_step[31:0];
        end
        mul_req.a = {17'd0, unwr_q[15:0]};
        mul_req.b = 18'(POLE_PAIRS);
        state_d   = ST_T_ELEC;
      end
      ST_T_ELEC: begin
        elec_d = prod[15:0];
        res_d  = tgt;
        case (mode_q[2:1])
          GRP_ANGLE: begin
            err_d    = pos_err;
            pi_sel_d = PI_POS;
            state_d  = ST_PI_P;
          end
          GRP_VELOCITY: state_d = ST_T_VEL;
          default:      state_d = ST_T_CUR;
        endcase
      end
      ST_T_VEL: begin
        err_d    = vel_err;
        pi_sel_d = PI_VEL;
        state_d  = ST_PI_P;
      end
      ST_T_CUR: begin
        if (mode_q[0]) begin
          if (cur_valid_q) begin
            err_d    = cur_err;
            pi_sel_d = PI_CUR;
            state_d  = ST_PI_P;
          end else begin
            res_d   = iq;
            state_d = ST_T_SLEW;
          end
        end else begin
          state_d = ST_T_SLEW;
        end
      end
      ST_PI_P: begin
        mul_req.a = err_q;
        mul_req.b = {2'd0, pi_kp};
        state_d   = ST_PI_I;
      end
      ST_PI_I: begin
        p_d       = prod[50:8];
        mul_req.a = err_q;
        mul_req.b = {2'd0, pi_ki};
        state_d   = ST_PI_A;
      end
      ST_PI_A: begin
        ni_d = pi_ni;
        if (pi_sel_q == PI_VEL) vel_int_d = pi_ni;
        if (pi_sel_q == PI_CUR) cur_int_d = pi_ni;
        state_d = ST_PI_O;
      end
      ST_PI_O: begin
        res_d = pi_out;
        case (pi_sel_q)
          PI_POS:  state_d = ST_T_VEL;
          PI_VEL:  state_d = ST_T_CUR;
          default: state_d = ST_T_SLEW;
        endcase
      end
      ST_T_SLEW: begin
        slewed_d = slewed_q + slew_step[15:0];
        state_d  = ST_T_STALL;
      end
      ST_T_STALL: begin
        if (vlim_q == 15'd0 || !stall_cond) begin
          stall_cnt_d = 16'd0;
        end else if (stall_inc >= 16'(STALL_TICKS)) begin
          // Timeout: back the integrators and the voltage off by half.
          vel_int_d   = halve32(vel_int_q);
          cur_int_d   = halve32(cur_int_q);
          slewed_d    = halve16(slewed_q);
          stall_cnt_d = 16'd0;
          stall_d     = 1'b1;
        end else begin
          stall_cnt_d = stall_inc;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {meas_q_q, meas_d_q, sat16({{2{filt_q[31]}}, filt_q}),
                         elec_q, slewed_q};
          out_stall_d = stall_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CONTROL_MODE: mode_d = cfg_data_i[2:0];
        REG_VEL_KP: begin
          vel_kp_d  = cfg_data_i;
          vel_int_d = 32'sd0;
        end
        REG_VEL_KI: begin
          vel_ki_d  = cfg_data_i;
          vel_int_d = 32'sd0;
        end
        REG_POS_KP: pos_kp_d = cfg_data_i;
        REG_CUR_KP: begin
          cur_kp_d  = cfg_data_i;
          cur_int_d = 32'sd0;
        end
        REG_CUR_KI: begin
          cur_ki_d  = cfg_data_i;
          cur_int_d = 32'sd0;
        end
        REG_VOLTAGE_LIMIT:  vlim_d   = cfg_data_i[14:0];
        REG_VELOCITY_LIMIT: vellim_d = cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pi_sel_q    <= PI_POS;
      mode_q      <= 3'd0;
      vel_kp_q    <= 16'd77;
      vel_ki_q    <= 16'd256;
      pos_kp_q    <= 16'd1280;
      cur_kp_q    <= 16'd256;
      cur_ki_q    <= 16'd0;
      vlim_q      <= 15'h7FFF;
      vellim_q    <= 15'd0;
      seen_q      <= 1'b0;
      cur_valid_q <= 1'b0;
      prev_q      <= 16'd0;
      elec_q      <= 16'd0;
      stall_cnt_q <= 16'd0;
      unwr_q      <= 32'd0;
      delta_q     <= 17'sd0;
      filt_q      <= 32'sd0;
      vel_int_q   <= 32'sd0;
      cur_int_q   <= 32'sd0;
      meas_d_q    <= 16'sd0;
      meas_q_q    <= 16'sd0;
      slewed_q    <= 16'sd0;
      out_valid_q <= 1'b0;
      stall_q     <= 1'b0;
      cos_pass_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pi_sel_q    <= pi_sel_d;
      mode_q      <= mode_d;
      vel_kp_q    <= vel_kp_d;
      vel_ki_q    <= vel_ki_d;
      pos_kp_q    <= pos_kp_d;
      cur_kp_q    <= cur_kp_d;
      cur_ki_q    <= cur_ki_d;
      vlim_q      <= vlim_d;
      vellim_q    <= vellim_d;
      seen_q      <= seen_d;
      cur_valid_q <= cur_valid_d;
      prev_q      <= prev_d;
      elec_q      <= elec_d;
      stall_cnt_q <= stall_cnt_d;
      unwr_q      <= unwr_d;
      delta_q     <= delta_d;
      filt_q      <= filt_d;
      vel_int_q   <= vel_int_d;
      cur_int_q   <= cur_int_d;
      meas_d_q    <= meas_d_d;
      meas_q_q    <= meas_q_d;
      slewed_q    <= slewed_d;
      out_valid_q <= out_valid_d;
      stall_q     <= stall_d;
      cos_pass_q  <= cos_pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_stall_q <= out_stall_d;
    dat_q       <= dat_d;
    neg_q       <= neg_d;
    alpha_q     <= alpha_d;
    beta_q      <= beta_d;
    z_q         <= z_d;
    z2_q        <= z2_d;
    sin_q       <= sin_d;
    cos_q       <= cos_d;
    acc_q       <= acc_d;
    err_q       <= err_d;
    p_q         <= p_d;
    ni_q        <= ni_d;
    res_q       <= res_d;
  end

  // An accepted item always starts the sequence.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q != ST_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_stall_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_cnt_q < 16'(STALL_TICKS))
    else $error("stall counter passed its timeout");

  a_slew_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slewed_q != 16'sh8000)
    else $error("slewed voltage left the symmetric range");

  a_stall_needs_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_T_STALL && stall_d |-> vlim_q != 15'd0)
    else $error("stall fired with an unlimited voltage");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && (!out_valid_q || m_axis_tready) |=> out_valid_q)
    else $error("finished result not presented");

endmodule
